[sv/hbs_pkg.sv]
// Shared types, constants and address helpers for the height map sampler.
// No dependencies; used by every other file of the block.
package hbs_pkg;

    localparam int MAP_W    = 256;
    localparam int MAP_H    = 256;
    localparam int ROW_W    = $clog2(MAP_H);
    localparam int COL_W    = $clog2(MAP_W);
    localparam int ADDR_W   = $clog2(MAP_W * MAP_H);
    localparam int DEPTH    = MAP_W * MAP_H;

    localparam int TEXEL_W  = 8;
    localparam int IDX_W    = 8;
    localparam int COORD_W  = 16;
    localparam int FRAC_W   = 8;
    localparam int HEIGHT_W = 16;
    localparam int MAXH_W   = 8;

    localparam int MUL_A_W  = 24;
    localparam int MUL_B_W  = 9;
    localparam int ACC_W    = 33;
    localparam int EST_W    = 17;

    localparam logic [1:0] MAC_HOLD = 2'd0;
    localparam logic [1:0] MAC_CLR  = 2'd1;
    localparam logic [1:0] MAC_ACC  = 2'd2;
    localparam logic [1:0] MAC_RND  = 2'd3;

    localparam logic [0:0] KIND_ACK    = 1'b0;
    localparam logic [0:0] KIND_HEIGHT = 1'b1;

    localparam logic [ACC_W-1:0]   ROUND_BIAS = 33'd32640;
    localparam logic [MUL_B_W-1:0] FRAC_ONE   = 9'd256;
    localparam logic [MUL_B_W-1:0] RECIP_255  = 9'd257;
    localparam logic [MUL_B_W-1:0] DIVISOR    = 9'd255;
    localparam logic [MUL_A_W-1:0] DIV_ONE    = 24'd255;
    localparam logic [MUL_A_W-1:0] DIV_TWO    = 24'd510;
    localparam logic [MAXH_W-1:0]  MAXH_RESET = 8'd60;

    typedef struct packed {
        logic [1:0]         op;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mac_cmd_t;

    function automatic logic [ROW_W-1:0] clamp_row(input logic [IDX_W:0] v);
        clamp_row = (v > (IDX_W+1)'(MAP_H - 1)) ? ROW_W'(MAP_H - 1) : v[ROW_W-1:0];
    endfunction

    function automatic logic [COL_W-1:0] clamp_col(input logic [IDX_W:0] v);
        clamp_col = (v > (IDX_W+1)'(MAP_W - 1)) ? COL_W'(MAP_W - 1) : v[COL_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] texel_addr(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        texel_addr = ADDR_W'(row) * ADDR_W'(MAP_W) + ADDR_W'(col);
    endfunction

endpackage

[sv/hbs_map_ram.sv]
// Single-port texel memory with registered read data.
// Depends on hbs_pkg for depth and widths.
module hbs_map_ram
(
    input  logic                          clk,
    input  logic                          we,
    input  logic [hbs_pkg::ADDR_W-1:0]    addr,
    input  logic [hbs_pkg::TEXEL_W-1:0]   wdata,
    output logic [hbs_pkg::TEXEL_W-1:0]   rdata
);

    logic [hbs_pkg::TEXEL_W-1:0] mem [0:hbs_pkg::DEPTH-1];
    logic [hbs_pkg::TEXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/hbs_mac.sv]
// Shared 24x9 multiply-accumulate unit with a registered accumulator.
// Depends on hbs_pkg for the command struct and op codes.
module hbs_mac
(
    input  logic                         clk,
    input  hbs_pkg::mac_cmd_t            cmd,
    output logic [hbs_pkg::ACC_W-1:0]    acc
);

    logic [hbs_pkg::ACC_W-1:0] acc_reg;
    logic [hbs_pkg::ACC_W-1:0] acc_next;
    logic [hbs_pkg::ACC_W-1:0] product;

    assign product = hbs_pkg::ACC_W'(cmd.a) * hbs_pkg::ACC_W'(cmd.b);

    always_comb
    begin
        unique case (cmd.op)
            hbs_pkg::MAC_HOLD: acc_next = acc_reg;
            hbs_pkg::MAC_CLR:  acc_next = product;
            hbs_pkg::MAC_ACC:  acc_next = acc_reg + product;
            hbs_pkg::MAC_RND:  acc_next = hbs_pkg::ROUND_BIAS + product;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[sv/heightmap_bilinear_sampler.sv]
// Bilinear height map sampler: holds a 256 x 256 map of 8-bit texels in one single-port
// memory. A load request writes one texel in the cycle it is accepted and is answered by an
// acknowledge with zero height in the next cycle. A query request (x = row, z = column,
// unsigned 8.8) is answered from S_R once the output is free; four texel reads go through
// the single memory port one per cycle, and the two interpolation passes, the max_height/255
// scaling and the divide by 255 take nine passes through one shared 24x9 multiply-accumulate
// unit. One request is in flight at a time. Depends on hbs_pkg, hbs_map_ram and hbs_mac.
module heightmap_bilinear_sampler
(
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            cfg_we,
    input  logic [hbs_pkg::MAXH_W-1:0]      cfg_wdata,

    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [hbs_pkg::IDX_W-1:0]       load_row,
    input  logic [hbs_pkg::IDX_W-1:0]       load_col,
    input  logic [hbs_pkg::TEXEL_W-1:0]     load_value,
    input  logic [hbs_pkg::COORD_W-1:0]     query_x,
    input  logic [hbs_pkg::COORD_W-1:0]     query_z,

    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            result_kind,
    output logic [hbs_pkg::HEIGHT_W-1:0]    height
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD0  = 4'd1;
    localparam logic [3:0] S_RD1  = 4'd2;
    localparam logic [3:0] S_RD2  = 4'd3;
    localparam logic [3:0] S_RD3  = 4'd4;
    localparam logic [3:0] S_A2   = 4'd5;
    localparam logic [3:0] S_V0   = 4'd6;
    localparam logic [3:0] S_V1   = 4'd7;
    localparam logic [3:0] S_H    = 4'd8;
    localparam logic [3:0] S_Q    = 4'd9;
    localparam logic [3:0] S_E    = 4'd10;
    localparam logic [3:0] S_R    = 4'd11;

    logic [3:0]                      state_reg;
    logic [3:0]                      state_next;
    logic [hbs_pkg::MAXH_W-1:0]      max_height_reg;
    logic [hbs_pkg::COORD_W-1:0]     x_reg;
    logic [hbs_pkg::COORD_W-1:0]     z_reg;
    logic [hbs_pkg::COORD_W-1:0]     a1_reg;
    logic [hbs_pkg::MUL_A_W-1:0]     q_reg;
    logic [hbs_pkg::EST_W-1:0]       est_reg;
    logic                            out_valid_reg;
    logic                            result_kind_reg;
    logic [hbs_pkg::HEIGHT_W-1:0]    height_reg;

    logic                            in_fire;
    logic                            load_fire;
    logic                            query_fire;
    logic                            slot_free;
    logic                            answer_fire;
    logic                            load_in_map;

    logic [hbs_pkg::ROW_W-1:0]       r1;
    logic [hbs_pkg::ROW_W-1:0]       r2;
    logic [hbs_pkg::COL_W-1:0]       c1;
    logic [hbs_pkg::COL_W-1:0]       c2;
    logic [hbs_pkg::MUL_B_W-1:0]     fx;
    logic [hbs_pkg::MUL_B_W-1:0]     fz;
    logic [hbs_pkg::MUL_B_W-1:0]     fx_inv;
    logic [hbs_pkg::MUL_B_W-1:0]     fz_inv;

    logic                            ram_we;
    logic [hbs_pkg::ADDR_W-1:0]      ram_addr;
    logic [hbs_pkg::TEXEL_W-1:0]     ram_rdata;

    hbs_pkg::mac_cmd_t               mac_cmd;
    logic [hbs_pkg::ACC_W-1:0]       acc;

    logic [hbs_pkg::MUL_A_W-1:0]     rem;
    logic [1:0]                      corr;
    logic [hbs_pkg::EST_W-1:0]       quot;

    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = (state_reg == S_IDLE) && (req_type || slot_free);
    assign in_fire     = in_valid && in_ready;
    assign load_fire   = in_fire && (req_type == hbs_pkg::KIND_ACK);
    assign query_fire  = in_fire && (req_type == hbs_pkg::KIND_HEIGHT);
    assign answer_fire = (state_reg == S_R) && slot_free;

    assign load_in_map = ({1'b0, load_row} < (hbs_pkg::IDX_W+1)'(hbs_pkg::MAP_H))
                      && ({1'b0, load_col} < (hbs_pkg::IDX_W+1)'(hbs_pkg::MAP_W));
    assign ram_we      = load_fire && load_in_map;

    assign r1 = hbs_pkg::clamp_row({1'b0, x_reg[hbs_pkg::COORD_W-1:hbs_pkg::FRAC_W]});
    assign r2 = hbs_pkg::clamp_row({1'b0, x_reg[hbs_pkg::COORD_W-1:hbs_pkg::FRAC_W]}
                                   + 9'd1);
    assign c1 = hbs_pkg::clamp_col({1'b0, z_reg[hbs_pkg::COORD_W-1:hbs_pkg::FRAC_W]});
    assign c2 = hbs_pkg::clamp_col({1'b0, z_reg[hbs_pkg::COORD_W-1:hbs_pkg::FRAC_W]}
                                   + 9'd1);

    assign fx     = {1'b0, x_reg[hbs_pkg::FRAC_W-1:0]};
    assign fz     = {1'b0, z_reg[hbs_pkg::FRAC_W-1:0]};
    assign fx_inv = hbs_pkg::FRAC_ONE - fx;
    assign fz_inv = hbs_pkg::FRAC_ONE - fz;

    // texel fetch order: (r1,c1) (r1,c2) (r2,c1) (r2,c2)
    always_comb
    begin
        unique case (state_reg)
            S_RD0:   ram_addr = hbs_pkg::texel_addr(r1, c1);
            S_RD1:   ram_addr = hbs_pkg::texel_addr(r1, c2);
            S_RD2:   ram_addr = hbs_pkg::texel_addr(r2, c1);
            S_RD3:   ram_addr = hbs_pkg::texel_addr(r2, c2);
            default: ram_addr = hbs_pkg::texel_addr(load_row[hbs_pkg::ROW_W-1:0],
                                                    load_col[hbs_pkg::COL_W-1:0]);
        endcase
    end

    hbs_map_ram u_map
    (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (load_value),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        mac_cmd.op = hbs_pkg::MAC_HOLD;
        mac_cmd.a  = '0;
        mac_cmd.b  = '0;
        unique case (state_reg)
            S_RD1:
            begin
                mac_cmd.op = hbs_pkg::MAC_CLR;
                mac_cmd.a  = hbs_pkg::MUL_A_W'(ram_rdata);
                mac_cmd.b  = fz_inv;
            end
            S_RD2:
            begin
                mac_cmd.op = hbs_pkg::MAC_ACC;
                mac_cmd.a  = hbs_pkg::MUL_A_W'(ram_rdata);
                mac_cmd.b  = fz;
            end
            S_RD3:
            begin
                mac_cmd.op = hbs_pkg::MAC_CLR;
                mac_cmd.a  = hbs_pkg::MUL_A_W'(ram_rdata);
                mac_cmd.b  = fz_inv;
            end
            S_A2:
            begin
                mac_cmd.op = hbs_pkg::MAC_ACC;
                mac_cmd.a  = hbs_pkg::MUL_A_W'(ram_rdata);
                mac_cmd.b  = fz;
            end
            S_V0:
            begin
                mac_cmd.op = hbs_pkg::MAC_CLR;
                mac_cmd.a  = hbs_pkg::MUL_A_W'(acc[hbs_pkg::COORD_W-1:0]);
                mac_cmd.b  = fx;
            end
            S_V1:
            begin
                mac_cmd.op = hbs_pkg::MAC_ACC;
                mac_cmd.a  = hbs_pkg::MUL_A_W'(a1_reg);
                mac_cmd.b  = fx_inv;
            end
            S_H:
            begin
                mac_cmd.op = hbs_pkg::MAC_RND;
                mac_cmd.a  = acc[hbs_pkg::MUL_A_W-1:0];
                mac_cmd.b  = hbs_pkg::MUL_B_W'(max_height_reg);
            end
            S_Q:
            begin
                mac_cmd.op = hbs_pkg::MAC_CLR;
                mac_cmd.a  = acc[hbs_pkg::MUL_A_W+7:8];
                mac_cmd.b  = hbs_pkg::RECIP_255;
            end
            S_E:
            begin
                mac_cmd.op = hbs_pkg::MAC_CLR;
                mac_cmd.a  = hbs_pkg::MUL_A_W'(acc[hbs_pkg::ACC_W-1:16]);
                mac_cmd.b  = hbs_pkg::DIVISOR;
            end
            default:
            begin
                mac_cmd.op = hbs_pkg::MAC_HOLD;
            end
        endcase
    end

    hbs_mac u_mac
    (
        .clk (clk),
        .cmd (mac_cmd),
        .acc (acc)
    );

    // reciprocal estimate runs low by at most two
    assign rem  = q_reg - acc[hbs_pkg::MUL_A_W-1:0];
    always_comb
    begin
        priority if (rem >= hbs_pkg::DIV_TWO)
        begin
            corr = 2'd2;
        end
        else if (rem >= hbs_pkg::DIV_ONE)
        begin
            corr = 2'd1;
        end
        else
        begin
            corr = 2'd0;
        end
    end
    assign quot = est_reg + hbs_pkg::EST_W'(corr);

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  state_next = query_fire ? S_RD0 : S_IDLE;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_A2;
            S_A2:    state_next = S_V0;
            S_V0:    state_next = S_V1;
            S_V1:    state_next = S_H;
            S_H:     state_next = S_Q;
            S_Q:     state_next = S_E;
            S_E:     state_next = S_R;
            S_R:     state_next = slot_free ? S_IDLE : S_R;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            max_height_reg <= hbs_pkg::MAXH_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                max_height_reg <= cfg_wdata;
            end
            if (load_fire || answer_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_fire)
        begin
            x_reg <= query_x;
            z_reg <= query_z;
        end
        if (state_reg == S_RD3)
        begin
            a1_reg <= acc[hbs_pkg::COORD_W-1:0];
        end
        if (state_reg == S_Q)
        begin
            q_reg <= acc[hbs_pkg::MUL_A_W+7:8];
        end
        if (state_reg == S_E)
        begin
            est_reg <= acc[hbs_pkg::ACC_W-1:16];
        end
        if (load_fire)
        begin
            result_kind_reg <= hbs_pkg::KIND_ACK;
            height_reg      <= '0;
        end
        else if (answer_fire)
        begin
            result_kind_reg <= hbs_pkg::KIND_HEIGHT;
            height_reg      <= quot[hbs_pkg::HEIGHT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = result_kind_reg;
    assign height      = height_reg;

    a_load_ack: assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> out_valid && (result_kind == hbs_pkg::KIND_ACK) && (height == '0))
        else $error("load request not acknowledged next cycle");

    a_query_start: assert property (@(posedge clk) disable iff (!rst_n)
        query_fire |=> (state_reg == S_RD0) && !out_valid_reg || (state_reg == S_RD0))
        else $error("query request did not start the texel fetch");

    a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_kind == hbs_pkg::KIND_HEIGHT)) |-> (height <= 16'd65280))
        else $error("height answer beyond full scale");

    a_answer_slot: assert property (@(posedge clk) disable iff (!rst_n)
        answer_fire |=> out_valid && (result_kind == hbs_pkg::KIND_HEIGHT)
                        && (state_reg == S_IDLE))
        else $error("height answer not presented");

endmodule

[tb/sv/tb.sv]
// Testbench for heightmap_bilinear_sampler: drives texel loads and bilinear height queries,
// predicts every acknowledge and height from its own copy of the map and of max_height.
// Depends on hbs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

    localparam logic [0:0] REQ_LOAD  = 1'b0;
    localparam logic [0:0] REQ_QUERY = 1'b1;
    localparam int HOLD_AT  = 700;
    localparam int HOLD_LEN = 600;

    typedef enum bit {RX_ALWAYS, RX_PATTERN} rx_mode_t;

    typedef struct packed {
        logic [0:0]                     kind;
        logic [hbs_pkg::IDX_W-1:0]      row;
        logic [hbs_pkg::IDX_W-1:0]      col;
        logic [hbs_pkg::TEXEL_W-1:0]    val;
        logic [hbs_pkg::COORD_W-1:0]    qx;
        logic [hbs_pkg::COORD_W-1:0]    qz;
    } map_request_t;

    typedef struct packed {
        logic [0:0]                     kind;
        logic [hbs_pkg::HEIGHT_W-1:0]   hgt;
    } height_result_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               cfg_we = 1'b0;
    logic [hbs_pkg::MAXH_W-1:0]         cfg_wdata = '0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               req_type = 1'b0;
    logic [hbs_pkg::IDX_W-1:0]          load_row = '0;
    logic [hbs_pkg::IDX_W-1:0]          load_col = '0;
    logic [hbs_pkg::TEXEL_W-1:0]        load_value = '0;
    logic [hbs_pkg::COORD_W-1:0]        query_x = '0;
    logic [hbs_pkg::COORD_W-1:0]        query_z = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic                               result_kind;
    logic [hbs_pkg::HEIGHT_W-1:0]       height;

    map_request_t                       request_q[$];
    height_result_t                     height_expect_q[$];
    int                                 anchors[$];

    bit [hbs_pkg::TEXEL_W-1:0]          tex_map [0:hbs_pkg::DEPTH-1];
    int unsigned                        mh_model = 32'(hbs_pkg::MAXH_RESET);

    int                                 gap_max = 0;
    rx_mode_t                           rx_mode = RX_ALWAYS;
    int                                 burst_left;
    int                                 gap_left;
    int                                 hold_cnt;
    bit                                 hold_armed;
    int                                 results_seen;
    int                                 mismatch_cnt = 0;
    logic [7:0]                         stall_pat;
    logic [5:0]                         pat_age;

    map_request_t                       pend;
    height_result_t                     want;
    height_result_t                     got;
    int unsigned                        r1, r2, c1, c2, fx, fz;
    longint unsigned                    a1, a2, mix, scaled;

    heightmap_bilinear_sampler dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .load_row    (load_row),
        .load_col    (load_col),
        .load_value  (load_value),
        .query_x     (query_x),
        .query_z     (query_z),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .height      (height)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned seen,
                                   input int unsigned wanted);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, seen, wanted);
        mismatch_cnt++;
    endtask

    // driver: offer requests in bursts, predict each one as it is accepted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (req_type == REQ_LOAD)
                begin
                    if (load_row < hbs_pkg::MAP_H && load_col < hbs_pkg::MAP_W)
                        tex_map[hbs_pkg::ADDR_W'(load_row * hbs_pkg::MAP_W + load_col)]
                            = load_value;
                    want.kind = hbs_pkg::KIND_ACK;
                    want.hgt  = '0;
                end
                else
                begin
                    fx = 32'(query_x[7:0]);
                    fz = 32'(query_z[7:0]);
                    r1 = 32'(query_x[15:8]);
                    c1 = 32'(query_z[15:8]);
                    r2 = r1 + 1;
                    c2 = c1 + 1;
                    if (r1 > hbs_pkg::MAP_H - 1) r1 = hbs_pkg::MAP_H - 1;
                    if (r2 > hbs_pkg::MAP_H - 1) r2 = hbs_pkg::MAP_H - 1;
                    if (c1 > hbs_pkg::MAP_W - 1) c1 = hbs_pkg::MAP_W - 1;
                    if (c2 > hbs_pkg::MAP_W - 1) c2 = hbs_pkg::MAP_W - 1;
                    a1 = longint'(tex_map[hbs_pkg::ADDR_W'(r1 * hbs_pkg::MAP_W + c1)])
                         * (256 - fz)
                       + longint'(tex_map[hbs_pkg::ADDR_W'(r1 * hbs_pkg::MAP_W + c2)]) * fz;
                    a2 = longint'(tex_map[hbs_pkg::ADDR_W'(r2 * hbs_pkg::MAP_W + c1)])
                         * (256 - fz)
                       + longint'(tex_map[hbs_pkg::ADDR_W'(r2 * hbs_pkg::MAP_W + c2)]) * fz;
                    mix = a1 * (256 - fx) + a2 * fx;
                    scaled = (mix * mh_model + 32640) / 65280;
                    if (scaled > 65535)
                        scaled = 65535;
                    want.kind = hbs_pkg::KIND_HEIGHT;
                    want.hgt  = scaled[hbs_pkg::HEIGHT_W-1:0];
                end
                height_expect_q.insert(height_expect_q.size(), want);
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left != 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (request_q.size() != 0)
                begin
                    pend = request_q.pop_front();
                    req_type   <= pend.kind;
                    load_row   <= pend.row;
                    load_col   <= pend.col;
                    load_value <= pend.val;
                    query_x    <= pend.qx;
                    query_z    <= pend.qz;
                    in_valid   <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        if (gap_max == 0 || $urandom_range(0, 3) == 0)
                            gap_left <= 0;
                        else
                            gap_left <= $urandom_range(1, gap_max);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt   <= 0;
            hold_armed <= 1'b1;
        end
        else if (hold_armed && results_seen >= HOLD_AT)
        begin
            hold_cnt   <= HOLD_LEN;
            hold_armed <= 1'b0;
        end
        else if (hold_cnt != 0)
            hold_cnt <= hold_cnt - 1;
    end

    // monitor: in pattern mode stall on a rotating pattern, check each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready    <= 1'b0;
            stall_pat    <= 8'hA5;
            pat_age      <= '0;
            results_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (height_expect_q.size() == 0)
                    report_mismatch("result with no request outstanding, height",
                                    32'(height), 0);
                else
                begin
                    got = height_expect_q.pop_front();
                    if (result_kind !== got.kind)
                        report_mismatch("result_kind", 32'(result_kind), 32'(got.kind));
                    if (height !== got.hgt)
                        report_mismatch("height", 32'(height), 32'(got.hgt));
                end
            end
            pat_age <= pat_age + 6'd1;
            if (pat_age == 6'd63)
                stall_pat <= 8'($urandom) | (8'h1 << $urandom_range(0, 7));
            else
                stall_pat <= {stall_pat[6:0], stall_pat[7]};
            out_ready <= (hold_cnt == 0) && (rx_mode == RX_ALWAYS || stall_pat[0]);
        end
    end

    function automatic logic [7:0] pick_frac();
        case ($urandom_range(0, 5))
            0: pick_frac = 8'h00;
            1: pick_frac = 8'hFF;
            2: pick_frac = 8'h80;
            default: pick_frac = 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_val();
        case ($urandom_range(0, 4))
            0: pick_val = 8'h00;
            1: pick_val = 8'hFF;
            default: pick_val = 8'($urandom);
        endcase
    endfunction

    function automatic int pick_index();
        case ($urandom_range(0, 19))
            0, 1: pick_index = 255;
            2, 3: pick_index = 254;
            4:    pick_index = 0;
            default: pick_index = $urandom_range(0, 255);
        endcase
    endfunction

    task automatic push_load(input int r, input int c, input logic [7:0] v);
        map_request_t req;
        req.kind = REQ_LOAD;
        req.row  = r[7:0];
        req.col  = c[7:0];
        req.val  = v;
        req.qx   = 16'($urandom);
        req.qz   = 16'($urandom);
        request_q.insert(request_q.size(), req);
    endtask

    task automatic push_query(input logic [15:0] x, input logic [15:0] z);
        map_request_t req;
        req.kind = REQ_QUERY;
        req.row  = 8'($urandom);
        req.col  = 8'($urandom);
        req.val  = 8'($urandom);
        req.qx   = x;
        req.qz   = z;
        request_q.insert(request_q.size(), req);
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (request_q.size() != 0 || in_valid || height_expect_q.size() != 0);
        repeat (16) @(negedge clk);
    endtask

    task automatic run_phase(input logic [7:0] mh, input int n_items, input int gmax,
                             input rx_mode_t rx);
        int count;
        int sel;
        int r;
        int c;
        int rn;
        int cn;
        int nq;
        int a;
        count = 0;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mh;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mh_model = 32'(mh);
        @(negedge clk);
        gap_max = gmax;
        rx_mode = rx;
        while (count < n_items)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
            begin
                r  = pick_index();
                c  = pick_index();
                rn = (r == 255) ? r : r + 1;
                cn = (c == 255) ? c : c + 1;
                push_load(r, c, pick_val());
                push_load(r, cn, pick_val());
                push_load(rn, c, pick_val());
                push_load(rn, cn, pick_val());
                anchors.insert(anchors.size(), r * 256 + c);
                nq = $urandom_range(1, 4);
                repeat (nq)
                    push_query({r[7:0], pick_frac()}, {c[7:0], pick_frac()});
                count += 4 + nq;
            end
            else if (sel < 85)
            begin
                push_load($urandom_range(0, 255), $urandom_range(0, 255), pick_val());
                count++;
            end
            else
            begin
                a = anchors[$urandom_range(0, anchors.size() - 1)];
                push_query({a[15:8], pick_frac()}, {a[7:0], pick_frac()});
                count++;
            end
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_load(0, 0, 8'd0);
        push_load(0, 1, 8'd255);
        push_load(1, 0, 8'd255);
        push_load(1, 1, 8'd128);
        push_load(254, 254, 8'd17);
        push_load(254, 255, 8'd200);
        push_load(255, 254, 8'd1);
        push_load(255, 255, 8'd255);
        anchors.insert(anchors.size(), 0);
        anchors.insert(anchors.size(), 254 * 256 + 254);
        anchors.insert(anchors.size(), 255 * 256 + 255);
        push_query(16'h0000, 16'h0000);
        push_query(16'h0080, 16'h0080);
        push_query(16'h00FF, 16'h00FF);
        push_query(16'h00FF, 16'h0000);
        push_query(16'h0000, 16'h00FF);
        push_query(16'hFFFF, 16'hFFFF);
        push_query(16'hFE80, 16'hFE40);
        push_query(16'hFF80, 16'hFE80);
        push_query(16'hFE80, 16'hFFC0);
        push_query(16'hFF00, 16'hFF00);
        push_query(16'hFEFF, 16'hFEFF);
        drain();

        run_phase(8'd255, 315, 0, RX_ALWAYS);
        run_phase(8'd0, 315, 12, RX_PATTERN);
        run_phase(8'd1, 315, 4, RX_PATTERN);
        run_phase(8'($urandom_range(2, 254)), 315, 8, RX_PATTERN);
        run_phase(8'd60, 315, 0, RX_PATTERN);
        run_phase(8'd255, 315, 16, RX_ALWAYS);

        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #800000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
sv/hbs_pkg.sv
sv/hbs_map_ram.sv
sv/hbs_mac.sv
sv/heightmap_bilinear_sampler.sv
tb/sv/tb.sv
